[rtl/tds_pkg.sv]
// Shared types, constants and helpers for the time-dependent tour search.
// Used by the interfaces, controller, datapath and top level.
package tds_pkg;

  localparam int MAX_CITIES = 8;
  localparam int MAX_DAYS   = 32;
  localparam int CITY_W     = $clog2(MAX_CITIES);
  localparam int DAY_W      = $clog2(MAX_DAYS);
  localparam int DCNT_W     = 6;
  localparam int CCNT_W     = 4;
  localparam int STAY_W     = 6;
  localparam int COST_W     = 32;
  localparam int TOTAL_W    = 40;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int ADDR_W     = DAY_W + 2 * CITY_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAY_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_STAY,
    OP_LOAD_COST,
    OP_START
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_LEG_ISSUE,
    ST_LEG_ACC,
    ST_COMMIT,
    ST_ADVANCE,
    ST_EMIT_LOAD,
    ST_EMIT
  } state_t;

  typedef logic [MAX_CITIES-1:0][CITY_W-1:0] order_t;
  typedef logic [MAX_CITIES-1:0][STAY_W-1:0] days_t;

  typedef struct packed {
    logic load_stay;
    logic load_cost;
    logic init;
    logic leg_issue;
    logic leg_acc;
    logic commit;
    logic advance;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic start_ok;
    logic leg_ok;
    logic at_return;
    logic has_next;
    logic out_last;
  } status_t;

  typedef struct packed {
    logic   valid;
    order_t order;
  } next_t;

  // Next lexicographic permutation of positions 0..m-1.
  function automatic next_t next_order(order_t t, logic [CITY_W-1:0] m);
    next_t             res;
    order_t            s;
    order_t            r;
    logic [CITY_W-1:0] i;
    logic [CITY_W-1:0] im1;
    logic [CITY_W-1:0] j;
    logic [CITY_W-1:0] src;
    i = '0;
    j = '0;
    for (int p = 1; p < MAX_CITIES; p++) begin
      if (CITY_W'(p) < m && t[p-1] < t[p]) i = CITY_W'(p);
    end
    im1 = i - CITY_W'(1);
    for (int p = 0; p < MAX_CITIES; p++) begin
      if (CITY_W'(p) < m && CITY_W'(p) >= i && t[p] > t[im1]) j = CITY_W'(p);
    end
    s = t;
    s[im1] = t[j];
    s[j] = t[im1];
    r = s;
    for (int p = 0; p < MAX_CITIES; p++) begin
      src = CITY_W'(i + m - CITY_W'(1) - CITY_W'(p));
      if (CITY_W'(p) >= i && CITY_W'(p) < m) r[p] = s[src];
    end
    res.valid = (m >= CITY_W'(2)) && (i != '0);
    res.order = r;
    return res;
  endfunction

endpackage

[rtl/tds_ifs.sv]
// Valid/ready channel interfaces for the tour search input and result items.
// Depend on tds_pkg for field widths.
interface tds_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [tds_pkg::CITY_W-1:0]    origin_city;
  logic [tds_pkg::CITY_W-1:0]    to_city;
  logic [tds_pkg::DAY_W-1:0]     leg_day;
  logic [tds_pkg::COST_W-1:0]    leg_cost;
  logic [tds_pkg::STAY_W-1:0]    stay_days;
  modport source (output valid, operation, origin_city, to_city, leg_day, leg_cost,
                  stay_days, input ready);
  modport sink (input valid, operation, origin_city, to_city, leg_day, leg_cost,
                stay_days, output ready);
endinterface

interface tds_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [tds_pkg::CITY_W-1:0]    dest_city;
  logic [tds_pkg::STAY_W-1:0]    travel_day;
  logic [tds_pkg::TOTAL_W-1:0]   tour_cost;
  logic                          last_leg;
  modport source (output valid, found, dest_city, travel_day, tour_cost, last_leg,
                  input ready);
  modport sink (input valid, found, dest_city, travel_day, tour_cost, last_leg,
                output ready);
endinterface

[rtl/tds_ctrl.sv]
// Sequencer for the tour search: loads, permutation walk, leg pricing, emit.
// Depends on tds_pkg; drives commands into tds_dp and reads its status.
module tds_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_operation,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  tds_pkg::status_t sts,
  output tds_pkg::cmd_t    cmd
);

  tds_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tds_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      tds_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_operation == tds_pkg::OP_LOAD_STAY) cmd.load_stay = 1'b1;
          if (in_operation == tds_pkg::OP_LOAD_COST) cmd.load_cost = 1'b1;
          if (in_operation == tds_pkg::OP_START) state_nxt = tds_pkg::ST_INIT;
        end
      end
      tds_pkg::ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = sts.start_ok ? tds_pkg::ST_LEG_ISSUE : tds_pkg::ST_EMIT_LOAD;
      end
      tds_pkg::ST_LEG_ISSUE: begin
        cmd.leg_issue = 1'b1;
        state_nxt = sts.leg_ok ? tds_pkg::ST_LEG_ACC : tds_pkg::ST_ADVANCE;
      end
      tds_pkg::ST_LEG_ACC: begin
        cmd.leg_acc = 1'b1;
        state_nxt = sts.at_return ? tds_pkg::ST_COMMIT : tds_pkg::ST_LEG_ISSUE;
      end
      tds_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = tds_pkg::ST_ADVANCE;
      end
      tds_pkg::ST_ADVANCE: begin
        cmd.advance = 1'b1;
        state_nxt = sts.has_next ? tds_pkg::ST_LEG_ISSUE : tds_pkg::ST_EMIT_LOAD;
      end
      tds_pkg::ST_EMIT_LOAD: begin
        cmd.emit_load = 1'b1;
        state_nxt     = tds_pkg::ST_EMIT;
      end
      tds_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.out_last) state_nxt = tds_pkg::ST_IDLE;
          else              cmd.emit_load = 1'b1;
        end
      end
      default: state_nxt = tds_pkg::ST_IDLE;
    endcase
  end

endmodule

[rtl/tds_dp.sv]
// Datapath for the tour search: cost memory, stay table, trial and best tours,
// running day and saturating cost sum, result register. Depends on tds_pkg.
module tds_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tds_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [tds_pkg::CITY_W-1:0]         in_origin_city,
  input  logic [tds_pkg::CITY_W-1:0]         in_to_city,
  input  logic [tds_pkg::DAY_W-1:0]          in_leg_day,
  input  logic [tds_pkg::COST_W-1:0]         in_leg_cost,
  input  logic [tds_pkg::STAY_W-1:0]         in_stay_days,
  input  tds_pkg::cmd_t                      cmd,
  output tds_pkg::status_t                   sts,
  output logic                               out_found,
  output logic [tds_pkg::CITY_W-1:0]         out_dest_city,
  output logic [tds_pkg::STAY_W-1:0]         out_travel_day,
  output logic [tds_pkg::TOTAL_W-1:0]        out_tour_cost,
  output logic                               out_last_leg
);

  localparam int CW = tds_pkg::CITY_W;
  localparam int SW = tds_pkg::STAY_W;

  logic [tds_pkg::COST_W-1:0] cost_mem [2**tds_pkg::ADDR_W];
  logic [tds_pkg::COST_W-1:0] rdata_r;
  logic [tds_pkg::ADDR_W-1:0] raddr;

  logic [SW-1:0] stay_r [tds_pkg::MAX_CITIES];

  logic [tds_pkg::CCNT_W-1:0] city_count_r;
  logic [tds_pkg::DCNT_W-1:0] day_count_r;
  logic [tds_pkg::CCNT_W-1:0] n_eff;
  logic [tds_pkg::DCNT_W-1:0] d_eff;
  logic [CW-1:0]              m;

  tds_pkg::order_t trial_r, best_order_r;
  tds_pkg::days_t  trial_days_r, best_days_r;
  logic [tds_pkg::TOTAL_W-1:0] sum_r, best_total_r;
  logic                        found_r;
  logic [CW-1:0]               k_r, e_r;
  logic [SW-1:0]               day_r, cur_stay_r;
  logic [CW-1:0]               prev_r;

  logic [CW-1:0]   to_city;
  logic [SW-1:0]   to_stay;
  logic [SW:0]     nd;
  logic [SW+1:0]   nd_next;
  logic [SW-1:0]   leg_day;
  logic [tds_pkg::TOTAL_W:0] sum_wide;
  tds_pkg::next_t  nxt;

  always_comb begin
    n_eff = (city_count_r > tds_pkg::CCNT_W'(tds_pkg::MAX_CITIES)) ?
            tds_pkg::CCNT_W'(tds_pkg::MAX_CITIES) : city_count_r;
    d_eff = (day_count_r > tds_pkg::DCNT_W'(tds_pkg::MAX_DAYS)) ?
            tds_pkg::DCNT_W'(tds_pkg::MAX_DAYS) : day_count_r;
    m = CW'(n_eff - tds_pkg::CCNT_W'(1));
  end

  // Leg k: first leg on day 0, middle legs check arrival plus stay,
  // the return leg only checks its own day.
  always_comb begin
    nd      = {1'b0, day_r} + {1'b0, cur_stay_r};
    to_city = (k_r == m) ? '0 : trial_r[k_r];
    to_stay = stay_r[to_city];
    nd_next = {1'b0, nd} + {2'b0, to_stay};
    if (k_r == '0) begin
      leg_day    = '0;
      sts.leg_ok = 1'b1;
    end else begin
      leg_day    = nd[SW-1:0];
      sts.leg_ok = (k_r == m) ? (nd < (SW+1)'(d_eff)) : (nd_next < (SW+2)'(d_eff));
    end
    raddr = {leg_day[tds_pkg::DAY_W-1:0], (k_r == '0) ? CW'(0) : prev_r, to_city};
    sum_wide = {1'b0, sum_r} + (tds_pkg::TOTAL_W+1)'(rdata_r);
    nxt = tds_pkg::next_order(trial_r, m);
    sts.start_ok  = (n_eff >= tds_pkg::CCNT_W'(2)) && (stay_r[0] < d_eff);
    sts.at_return = (k_r == m);
    sts.has_next  = nxt.valid;
    sts.out_last  = out_last_leg;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cost) cost_mem[{in_leg_day, in_origin_city, in_to_city}] <= in_leg_cost;
    rdata_r <= cost_mem[raddr];
    if (cmd.load_stay) stay_r[in_origin_city] <= in_stay_days;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= tds_pkg::CCNT_W'(1);
      day_count_r  <= tds_pkg::DCNT_W'(1);
      trial_r      <= '0;
      best_order_r <= '0;
      best_days_r  <= '0;
      best_total_r <= '1;
      found_r      <= 1'b0;
      k_r          <= '0;
      e_r          <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == tds_pkg::CFG_CITY_COUNT)
          city_count_r <= cfg_data[tds_pkg::CCNT_W-1:0];
        if (cfg_index == tds_pkg::CFG_DAY_COUNT) day_count_r <= cfg_data;
      end
      if (cmd.init) begin
        for (int p = 0; p < tds_pkg::MAX_CITIES; p++)
          trial_r[p] <= (CW'(p) < m) ? CW'(p + 1) : '0;
        best_order_r <= '0;
        best_days_r  <= '0;
        best_total_r <= '1;
        found_r      <= 1'b0;
        k_r          <= '0;
        e_r          <= '0;
      end
      if (cmd.leg_acc && !sts.at_return) k_r <= k_r + CW'(1);
      if (cmd.commit && (!found_r || sum_r < best_total_r)) begin
        found_r      <= 1'b1;
        best_total_r <= sum_r;
        best_order_r <= trial_r;
        best_days_r  <= trial_days_r;
      end
      if (cmd.advance) begin
        k_r <= '0;
        if (nxt.valid) trial_r <= nxt.order;
      end
      if (cmd.emit_load) e_r <= e_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init || cmd.advance) begin
      sum_r <= '0;
      day_r <= '0;
    end
    if (cmd.leg_issue) begin
      day_r             <= leg_day;
      cur_stay_r        <= to_stay;
      prev_r            <= to_city;
      trial_days_r[k_r] <= leg_day;
    end
    if (cmd.leg_acc)
      sum_r <= sum_wide[tds_pkg::TOTAL_W] ? '1 : sum_wide[tds_pkg::TOTAL_W-1:0];
    if (cmd.emit_load) begin
      out_found      <= found_r;
      out_dest_city  <= (found_r && e_r != m) ? best_order_r[e_r] : '0;
      out_travel_day <= found_r ? best_days_r[e_r] : '0;
      out_tour_cost  <= found_r ? best_total_r : '0;
      out_last_leg   <= !found_r || (e_r == m);
    end
  end

endmodule

[rtl/time_dependent_tour_search.sv]
// Top level of the time-dependent tour search.
// Depends on tds_pkg, tds_ifs, tds_ctrl and tds_dp.
//
// Input channel in_ch: operation 0 loads a stay length, 1 loads one leg cost
// (day, from, to), 2 starts a search. Loads are taken back to back. A start
// tries every order of cities 1..n-1, leaving from and returning to city 0,
// pricing each leg from the cost memory on its travel day.
// Each leg is priced by a memory read, then a saturating add; a feasible
// order is then compared with the best, and every order steps to the next
// permutation. An order is dropped at its first infeasible leg.
// Result channel out_ch: n results, one per leg of the cheapest tour, each
// carrying the total cost; last_leg marks the final one. With no feasible
// tour a single not-found result is given. Results come from a register that
// holds while out_ch.ready is low; no new item is taken until the last
// result has transferred. cfg_* writes city_count (0) or day_count (1).
// Reset sets city_count and day_count to 1; cost and stay tables hold
// whatever they held until loaded.
module time_dependent_tour_search (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tds_pkg::CFG_DATA_W-1:0]  cfg_data,
  tds_in_if.sink                          in_ch,
  tds_out_if.source                       out_ch
);

  tds_pkg::cmd_t    cmd;
  tds_pkg::status_t sts;

  tds_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  tds_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_origin_city (in_ch.origin_city),
    .in_to_city     (in_ch.to_city),
    .in_leg_day     (in_ch.leg_day),
    .in_leg_cost    (in_ch.leg_cost),
    .in_stay_days   (in_ch.stay_days),
    .cmd            (cmd),
    .sts            (sts),
    .out_found      (out_ch.found),
    .out_dest_city  (out_ch.dest_city),
    .out_travel_day (out_ch.travel_day),
    .out_tour_cost  (out_ch.tour_cost),
    .out_last_leg   (out_ch.last_leg)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while a result is pending");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.operation == tds_pkg::OP_START)
    |=> !in_ch.ready)
    else $error("input ready right after a start");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_leg) |=> in_ch.ready)
    else $error("not idle after final result");

  a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |-> out_ch.last_leg)
    else $error("not-found result not marked last");

endmodule

[dv/tds_checker.sv]
// Checker for the tour search: watches config writes and both channels,
// predicts the result of every search and compares results field by field.
// Depends on tds_pkg and the tds_in_if / tds_out_if interfaces.
module tds_checker (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [tds_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [tds_pkg::CFG_DATA_W-1:0]           cfg_data,
  tds_in_if                                        in_ch,
  tds_out_if                                       out_ch,
  output int                                       fail_count,
  output int                                       legs_pending
);

  typedef struct {
    logic                          found;
    logic [tds_pkg::CITY_W-1:0]    dest_city;
    logic [tds_pkg::STAY_W-1:0]    travel_day;
    logic [tds_pkg::TOTAL_W-1:0]   tour_cost;
    logic                          last_leg;
  } leg_t;

  localparam logic [tds_pkg::TOTAL_W-1:0] COST_SAT = '1;

  logic [tds_pkg::COST_W-1:0] leg_cost_tab
                              [tds_pkg::MAX_DAYS*tds_pkg::MAX_CITIES*tds_pkg::MAX_CITIES];
  logic [tds_pkg::STAY_W-1:0] stay_tab [tds_pkg::MAX_CITIES];
  logic [tds_pkg::CCNT_W-1:0] n_cities;
  logic [tds_pkg::DCNT_W-1:0] n_days;
  leg_t                       tour_legs[$];
  int                         visit[tds_pkg::MAX_CITIES];

  assign legs_pending = tour_legs.size();

  function automatic logic [tds_pkg::TOTAL_W-1:0] sat_sum(
      logic [tds_pkg::TOTAL_W-1:0] a, logic [tds_pkg::COST_W-1:0] b);
    logic [tds_pkg::TOTAL_W:0] s;
    s = a + b;
    return (s > COST_SAT) ? COST_SAT : s[tds_pkg::TOTAL_W-1:0];
  endfunction

  function automatic logic [tds_pkg::COST_W-1:0] price(int d, int f, int t);
    return leg_cost_tab[(d * tds_pkg::MAX_CITIES + f) * tds_pkg::MAX_CITIES + t];
  endfunction

  // Prices the visit order over m cities; 0 when a leg runs out of days.
  function automatic bit price_visit(int m, int dlim,
                                     output logic [tds_pkg::TOTAL_W-1:0] total,
                                     output int leg_days[tds_pkg::MAX_CITIES+1]);
    int day;
    int nd;
    total = price(0, 0, visit[0]);
    day = 0;
    leg_days[0] = 0;
    for (int k = 1; k < m; k++) begin
      nd = day + stay_tab[visit[k-1]];
      if (nd + stay_tab[visit[k]] >= dlim) return 0;
      total = sat_sum(total, price(nd, visit[k-1], visit[k]));
      day = nd;
      leg_days[k] = nd;
    end
    nd = day + stay_tab[visit[m-1]];
    if (nd >= dlim) return 0;
    total = sat_sum(total, price(nd, visit[m-1], 0));
    leg_days[m] = nd;
    return 1;
  endfunction

  function automatic bit step_visit(int m);
    int i;
    int j;
    int t;
    int lo;
    int hi;
    if (m < 2) return 0;
    i = m - 1;
    while (i > 0 && visit[i-1] >= visit[i]) i--;
    if (i == 0) return 0;
    j = m - 1;
    while (visit[j] <= visit[i-1]) j--;
    t = visit[i-1]; visit[i-1] = visit[j]; visit[j] = t;
    lo = i;
    hi = m - 1;
    while (lo < hi) begin
      t = visit[lo]; visit[lo] = visit[hi]; visit[hi] = t;
      lo++;
      hi--;
    end
    return 1;
  endfunction

  function automatic void predict_tour();
    int n;
    int dlim;
    int m;
    bit got;
    int best_visit[tds_pkg::MAX_CITIES];
    int best_days[tds_pkg::MAX_CITIES+1];
    int leg_days[tds_pkg::MAX_CITIES+1];
    logic [tds_pkg::TOTAL_W-1:0] best_total;
    logic [tds_pkg::TOTAL_W-1:0] total;
    leg_t r;
    n = (n_cities > tds_pkg::MAX_CITIES) ? tds_pkg::MAX_CITIES : n_cities;
    dlim = (n_days > tds_pkg::MAX_DAYS) ? tds_pkg::MAX_DAYS : n_days;
    m = n - 1;
    got = 0;
    best_total = COST_SAT;
    if (n >= 2 && stay_tab[0] < dlim) begin
      for (int k = 0; k < m; k++) visit[k] = k + 1;
      do begin
        if (price_visit(m, dlim, total, leg_days) && (!got || total < best_total)) begin
          got = 1;
          best_total = total;
          best_visit = visit;
          best_days = leg_days;
        end
      end while (step_visit(m));
    end
    if (!got) begin
      r = '{1'b0, '0, '0, '0, 1'b1};
      tour_legs = {tour_legs, r};
    end else begin
      for (int k = 0; k <= m; k++) begin
        r.found      = 1'b1;
        r.dest_city  = (k < m) ? tds_pkg::CITY_W'(best_visit[k]) : '0;
        r.travel_day = tds_pkg::STAY_W'(best_days[k]);
        r.tour_cost  = best_total;
        r.last_leg   = (k == m);
        tour_legs = {tour_legs, r};
      end
    end
  endfunction

  always @(posedge clk) begin
    leg_t e;
    if (!rst_n) begin
      n_cities <= tds_pkg::CCNT_W'(1);
      n_days <= tds_pkg::DCNT_W'(1);
      tour_legs.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == tds_pkg::CFG_CITY_COUNT) n_cities <= cfg_data[tds_pkg::CCNT_W-1:0];
        else n_days <= cfg_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.operation)
          tds_pkg::OP_LOAD_STAY: stay_tab[in_ch.origin_city] = in_ch.stay_days;
          tds_pkg::OP_LOAD_COST:
            leg_cost_tab[(in_ch.leg_day * tds_pkg::MAX_CITIES + in_ch.origin_city)
                         * tds_pkg::MAX_CITIES + in_ch.to_city] = in_ch.leg_cost;
          tds_pkg::OP_START: predict_tour();
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (tour_legs.size() == 0) begin
          $error("result with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = tour_legs.pop_front();
          if (out_ch.found !== e.found ||
              out_ch.dest_city !== e.dest_city ||
              out_ch.travel_day !== e.travel_day ||
              out_ch.tour_cost !== e.tour_cost ||
              out_ch.last_leg !== e.last_leg) begin
            fail_count <= fail_count + 1;
            if (out_ch.found !== e.found)
              $error("found: expected %0d, got %0d", e.found, out_ch.found);
            if (out_ch.dest_city !== e.dest_city)
              $error("dest_city: expected %0d, got %0d", e.dest_city, out_ch.dest_city);
            if (out_ch.travel_day !== e.travel_day)
              $error("travel_day: expected %0d, got %0d", e.travel_day, out_ch.travel_day);
            if (out_ch.tour_cost !== e.tour_cost)
              $error("tour_cost: expected %0h, got %0h", e.tour_cost, out_ch.tour_cost);
            if (out_ch.last_leg !== e.last_leg)
              $error("last_leg: expected %0d, got %0d", e.last_leg, out_ch.last_leg);
          end
        end
      end
    end
  end
endmodule

[dv/tb_top.sv]
// Testbench top for the tour search: clock, reset, stimulus and verdict.
// Depends on tds_pkg, the RTL interfaces, time_dependent_tour_search and tds_checker.
module tb_top;

  localparam logic [1:0] OP_UNUSED = 2'b11;
  localparam int IDLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [tds_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tds_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count;
  int legs_pending;
  int quiet_cycles = 0;
  bit long_hold = 0;
  bit no_gaps = 0;

  tds_in_if in_ch();
  tds_out_if out_ch();

  time_dependent_tour_search uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  tds_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .legs_pending(legs_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.origin_city = '0;
    in_ch.to_city = '0;
    in_ch.leg_day = '0;
    in_ch.leg_cost = '0;
    in_ch.stay_days = '0;
    out_ch.ready = 1'b0;
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random stalls, bursts without stalls, one long hold-off
  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        w = 400;
        long_hold = 0;
      end else begin
        w = no_gaps ? 0 : $urandom_range(0, 4);
      end
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  task automatic send(logic [1:0] op, int from, int to, int day, logic [31:0] cost, int stay);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.operation <= op;
    in_ch.origin_city <= tds_pkg::CITY_W'(from);
    in_ch.to_city <= tds_pkg::CITY_W'(to);
    in_ch.leg_day <= tds_pkg::DAY_W'(day);
    in_ch.leg_cost <= cost;
    in_ch.stay_days <= tds_pkg::STAY_W'(stay);
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
  endtask

  task automatic start_search();
    send(tds_pkg::OP_START, $urandom_range(0, 7), $urandom_range(0, 7),
         $urandom_range(0, 31), $urandom, $urandom_range(0, 32));
  endtask

  // Wait out all results, then enough cycles for a trailing load to retire
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (legs_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(int cities, int days);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= tds_pkg::CFG_CITY_COUNT;
    cfg_data <= tds_pkg::CFG_DATA_W'(cities);
    @(posedge clk);
    cfg_index <= tds_pkg::CFG_DAY_COUNT;
    cfg_data <= tds_pkg::CFG_DATA_W'(days);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // City 0 may block the start; cities 1..3 stay 0 or 1 days, the rest 0
  function automatic int pick_stay(int city);
    if (city == 0) return ($urandom_range(0, 3) == 0) ? $urandom_range(30, 32) : 0;
    return $urandom_range(0, 1);
  endfunction

  function automatic logic [31:0] pick_cost();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 3);
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Costs are only loaded for day 0, or day 1 among cities 0..3, which is all
  // that a search can price under the phase limits below
  task automatic random_load();
    int r;
    int c;
    int d;
    int f;
    int t;
    r = $urandom_range(0, 9);
    c = $urandom_range(0, 3);
    d = $urandom_range(0, 1);
    f = (d == 0) ? $urandom_range(0, 7) : c;
    t = (d == 0) ? $urandom_range(0, 7) : $urandom_range(0, 3);
    if (r < 4) send(tds_pkg::OP_LOAD_STAY, c, $urandom_range(0, 7),
                    $urandom_range(0, 31), $urandom, pick_stay(c));
    else if (r < 9) send(tds_pkg::OP_LOAD_COST, f, t, d, pick_cost(),
                         $urandom_range(0, 32));
    else send(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
              $urandom_range(0, 31), $urandom, $urandom_range(0, 32));
  endtask

  initial begin
    int cities;
    int days;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Stays all zero; day 0 for every pair of distinct cities, day 1 for
    // cities 0..3. Equal day 0 costs among cities 0..2 give a tie.
    no_gaps = 1;
    for (int c = 0; c < tds_pkg::MAX_CITIES; c++) send(tds_pkg::OP_LOAD_STAY, c, 0, 0, 0, 0);
    for (int f = 0; f < tds_pkg::MAX_CITIES; f++)
      for (int t = 0; t < tds_pkg::MAX_CITIES; t++)
        if (f != t)
          send(tds_pkg::OP_LOAD_COST, f, t, 0, (f < 3 && t < 3) ? 32'd5 : pick_cost(), 0);
    for (int f = 0; f < 4; f++)
      for (int t = 0; t < 4; t++)
        if (f != t) send(tds_pkg::OP_LOAD_COST, f, t, 1, pick_cost(), 0);
    no_gaps = 0;

    // Directed: few cities, zero count, ties, full size, large registers
    start_search();
    configure(0, 32);
    start_search();
    configure(2, 1);
    start_search();
    configure(3, 1);
    start_search();
    configure(8, 32);
    start_search();
    configure(15, 63);
    send(OP_UNUSED, 7, 7, 31, 32'hFFFF_FFFF, 63);
    send(tds_pkg::OP_LOAD_COST, 7, 0, 0, 32'hFFFF_FFFF, 0);
    start_search();
    configure(4, 0);
    start_search();
    configure(4, 32);
    send(tds_pkg::OP_LOAD_STAY, 0, 0, 0, 0, 32);
    start_search();
    send(tds_pkg::OP_LOAD_STAY, 0, 0, 0, 0, 31);
    send(tds_pkg::OP_LOAD_STAY, 3, 0, 0, 0, 1);
    start_search();
    send(tds_pkg::OP_LOAD_STAY, 0, 0, 0, 0, 0);

    // Receiver holds off while the sender keeps offering items
    configure(4, 32);
    long_hold = 1;
    start_search();
    for (int k = 0; k < 4; k++) random_load();

    // Random phases: day_count kept to 2 for small tours, 1 for larger ones
    for (int p = 0; p < 5; p++) begin
      cities = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 4);
      days = (cities > 4) ? 1 : $urandom_range(0, 2);
      configure(cities, days);
      no_gaps = (p == 2);
      for (int k = $urandom_range(1, 3); k > 0; k--) random_load();
      start_search();
      if ($urandom_range(0, 1)) start_search();
      no_gaps = 0;
    end
    settle();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && legs_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

[time_dependent_tour_search.f]
rtl/tds_pkg.sv
rtl/tds_ifs.sv
rtl/tds_ctrl.sv
rtl/tds_dp.sv
rtl/time_dependent_tour_search.sv
dv/tds_checker.sv
dv/tb_top.sv
